// ----- design/k_combination_enumerator_assert.svh -----
// Assertion macros used by the enumerator sequencer.
`ifndef K_COMBINATION_ENUMERATOR_ASSERT_SVH
`define K_COMBINATION_ENUMERATOR_ASSERT_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define KCE_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define KCE_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- design/kce_pkg.sv -----
// Shared constants and types of the k-combination enumerator.
`timescale 1ns / 1ps
`default_nettype none

package kce_pkg;

  localparam int MaxSamples = 16;
  localparam int MaxTotal   = 1024;
  localparam int IdxW       = 10;
  localparam int SlotW      = 4;
  localparam int KW         = 5;
  localparam int NW         = 11;
  localparam int CfgIdxW    = 2;

  typedef logic [IdxW-1:0]    index_t;
  typedef logic [SlotW-1:0]   slot_t;
  typedef logic [KW-1:0]      ksize_t;
  typedef logic [NW-1:0]      nsize_t;
  typedef logic [CfgIdxW-1:0] cfg_idx_t;

  localparam cfg_idx_t RegSubsetSize = cfg_idx_t'(0);
  localparam cfg_idx_t RegPoolSize   = cfg_idx_t'(1);

  // Request from the sequencer to the subset store.
  typedef struct packed {
    logic   clear;
    logic   wr_en;
    slot_t  wr_addr;
    index_t wr_data;
    slot_t  rd_addr;
  } store_req_t;

endpackage

`default_nettype wire

// ----- design/kce_store.sv -----
// Register file holding the current subset, one index per position.
`timescale 1ns / 1ps
`default_nettype none

module kce_store (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire kce_pkg::store_req_t req,
  output      kce_pkg::index_t     rd_data
);
  import kce_pkg::*;

  index_t mem_r [MaxSamples];

  // Reset and clear load the first subset: position p holds p.
  always_ff @(posedge clk) begin
    if (!rst_n || req.clear) begin
      for (int i = 0; i < MaxSamples; i++) begin
        mem_r[i] <= index_t'(i);
      end
    end else if (req.wr_en) begin
      mem_r[req.wr_addr] <= req.wr_data;
    end
  end

  assign rd_data = mem_r[req.rd_addr];

endmodule

`default_nettype wire

// ----- design/kce_seq.sv -----
// Draw sequencer: scan for the pivot, emit indices, advance the subset.
`timescale 1ns / 1ps
`default_nettype none

module kce_seq (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire kce_pkg::ksize_t     k,
  input  wire kce_pkg::nsize_t     n,
  input  wire logic                in_valid,
  output      logic                in_ready,
  input  wire logic                in_restart,
  output      kce_pkg::store_req_t req,
  input  wire kce_pkg::index_t     rd_data,
  output      logic                out_valid,
  input  wire logic                out_ready,
  output      kce_pkg::index_t     out_index,
  output      kce_pkg::slot_t      out_slot,
  output      logic                out_last,
  output      logic                out_wrapped,
  output      logic                out_error
);
  import kce_pkg::*;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_SCAN = 2'd1;
  localparam logic [1:0] ST_EMIT = 2'd2;
  localparam logic [1:0] ST_ERR  = 2'd3;

  logic [1:0] state_r, state_nxt;
  slot_t      idx_r, idx_nxt;
  slot_t      pos_r, pos_nxt;
  slot_t      p_r, p_nxt;
  logic       found_r, found_nxt;
  nsize_t     nk_r, nk_nxt;
  index_t     run_r, run_nxt;

  logic   out_valid_r, out_valid_nxt;
  index_t out_index_r, out_index_nxt;
  slot_t  out_slot_r, out_slot_nxt;
  logic   out_last_r, out_last_nxt;
  logic   out_wrapped_r, out_wrapped_nxt;
  logic   out_error_r, out_error_nxt;

  logic                accept;
  logic                bad_cfg;
  logic                ld;
  logic                hit;
  logic                is_last;
  logic [NW-1:0]       opa;
  logic [SlotW-1:0]    opb;
  logic [NW:0]         sum;

  assign in_ready = (state_r == ST_IDLE);
  assign accept   = in_valid && in_ready;
  assign ld       = !out_valid_r || out_ready;

  assign bad_cfg = (k == '0) || (n == '0) || ({{(NW-KW){1'b0}}, k} > n) ||
                   (k > ksize_t'(MaxSamples)) || (n > nsize_t'(MaxTotal));

  assign is_last = ({1'b0, p_r} == (k - ksize_t'(1)));

  // Shared adder: limit N-K+i while scanning, increment while emitting.
  always_comb begin
    if (state_r == ST_SCAN) begin
      opa = nk_r;
      opb = idx_r;
    end else begin
      opa = {1'b0, ((p_r == pos_r) ? rd_data : run_r)};
      opb = slot_t'(1);
    end
  end
  assign sum = {1'b0, opa} + {{(NW+1-SlotW){1'b0}}, opb};
  assign hit = ({2'b0, rd_data} < sum);

  always_comb begin
    state_nxt       = state_r;
    idx_nxt         = idx_r;
    pos_nxt         = pos_r;
    p_nxt           = p_r;
    found_nxt       = found_r;
    nk_nxt          = nk_r;
    run_nxt         = run_r;
    out_valid_nxt   = out_valid_r && !out_ready;
    out_index_nxt   = out_index_r;
    out_slot_nxt    = out_slot_r;
    out_last_nxt    = out_last_r;
    out_wrapped_nxt = out_wrapped_r;
    out_error_nxt   = out_error_r;
    req.clear       = 1'b0;
    req.wr_en       = 1'b0;
    req.wr_addr     = p_r;
    req.wr_data     = sum[IdxW-1:0];
    req.rd_addr     = (state_r == ST_SCAN) ? idx_r : p_r;

    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          req.clear = in_restart;
          if (bad_cfg) begin
            state_nxt = ST_ERR;
          end else begin
            idx_nxt   = slot_t'(k - ksize_t'(1));
            nk_nxt    = n - {{(NW-KW){1'b0}}, k};
            state_nxt = ST_SCAN;
          end
        end
      end
      ST_SCAN: begin
        // Walk from the rightmost position toward slot 0.
        if (hit) begin
          found_nxt = 1'b1;
          pos_nxt   = idx_r;
          p_nxt     = '0;
          state_nxt = ST_EMIT;
        end else if (idx_r == '0) begin
          found_nxt = 1'b0;
          p_nxt     = '0;
          state_nxt = ST_EMIT;
        end else begin
          idx_nxt = idx_r - slot_t'(1);
        end
      end
      ST_EMIT: begin
        if (ld) begin
          out_valid_nxt   = 1'b1;
          out_index_nxt   = rd_data;
          out_slot_nxt    = p_r;
          out_last_nxt    = is_last;
          out_wrapped_nxt = !found_r;
          out_error_nxt   = 1'b0;
          // Advance in place: bump the pivot, refill the tail consecutively.
          if (found_r && (p_r >= pos_r)) begin
            req.wr_en = 1'b1;
            run_nxt   = sum[IdxW-1:0];
          end
          if (is_last) begin
            req.clear = !found_r;
            state_nxt = ST_IDLE;
          end else begin
            p_nxt = p_r + slot_t'(1);
          end
        end
      end
      ST_ERR: begin
        if (ld) begin
          out_valid_nxt   = 1'b1;
          out_index_nxt   = '0;
          out_slot_nxt    = '0;
          out_last_nxt    = 1'b1;
          out_wrapped_nxt = 1'b0;
          out_error_nxt   = 1'b1;
          state_nxt       = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      found_r     <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      found_r     <= found_nxt;
    end
  end

  always_ff @(posedge clk) begin
    idx_r         <= idx_nxt;
    pos_r         <= pos_nxt;
    p_r           <= p_nxt;
    nk_r          <= nk_nxt;
    run_r         <= run_nxt;
    out_index_r   <= out_index_nxt;
    out_slot_r    <= out_slot_nxt;
    out_last_r    <= out_last_nxt;
    out_wrapped_r <= out_wrapped_nxt;
    out_error_r   <= out_error_nxt;
  end

  assign out_valid   = out_valid_r;
  assign out_index   = out_index_r;
  assign out_slot    = out_slot_r;
  assign out_last    = out_last_r;
  assign out_wrapped = out_wrapped_r;
  assign out_error   = out_error_r;

`include "k_combination_enumerator_assert.svh"

  `KCE_ASSERT_IMP(a_err_single, out_valid_r && out_error_r, out_last_r && (out_slot_r == '0) && !out_wrapped_r, "error result malformed")
  `KCE_ASSERT_IMP(a_scan_range, state_r == ST_SCAN, {1'b0, idx_r} < k, "scan position beyond subset")
  `KCE_ASSERT_IMP(a_pivot_range, (state_r == ST_EMIT) && found_r, {1'b0, pos_r} < k, "pivot beyond subset")
  `KCE_ASSERT_NXT(a_good_to_scan, accept && !bad_cfg, state_r == ST_SCAN, "valid draw did not start scan")

endmodule

`default_nettype wire

// ----- design/k_combination_enumerator.sv -----
// Top level of the lexicographic k-combination enumerator.
`timescale 1ns / 1ps
`default_nettype none

// Usage:
//   Configure subset size K (register 0) and pool size N (register 1) on the
//   cfg_ channel while the block is idle; a write to either register returns the enumeration
//   to the first subset {0..K-1}. cfg_ready is always high.
//   Each request on in_ (in_tdata bit 0 = restart) draws the current subset:
//   K results on out_, indices ascending, slot 0..K-1, tlast on slot K-1.
//   out_tuser bit 0 marks the final subset {N-K..N-1}, after which the
//   enumeration wraps. A setting with K > N, K or N zero, or out of range
//   gives a single result with out_tuser bit 1 (error) and tlast set.
// Timing:
//   A draw scans from slot K-1 down to the pivot, one compare per cycle on
//   the shared adder, then emits one index per cycle while out_tready allows,
//   as the same adder rewrites the tail. in_tready is high only between draws.
// Reset: synchronous, active low; K = N = 1, store holds the first subset.
// Stall: a result waits in the output register while out_tready is low and
//   the sequencer holds until it is taken.

module k_combination_enumerator (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   in_tvalid,
  output      logic                   in_tready,
  input  wire logic [7:0]             in_tdata,   // [0] restart, [7:1] zero
  output      logic                   out_tvalid,
  input  wire logic                   out_tready,
  output      logic [15:0]            out_tdata,  // [9:0] chosen_index, [13:10] slot
  output      logic                   out_tlast,  // last_of_subset
  output      logic [1:0]             out_tuser,  // [0] wrapped, [1] error
  input  wire logic                   cfg_valid,
  output      logic                   cfg_ready,
  input  wire kce_pkg::cfg_idx_t      cfg_index,
  input  wire logic [kce_pkg::NW-1:0] cfg_data
);
  import kce_pkg::*;

  ksize_t     k_r, k_nxt;
  nsize_t     n_r, n_nxt;
  logic       cfg_clear;
  store_req_t seq_req;
  store_req_t store_req;
  index_t     rd_data;
  index_t     out_index;
  slot_t      out_slot;
  logic       out_wrapped;
  logic       out_error;

  assign cfg_ready = 1'b1;

  // Register writes; a write to either register restarts the enumeration.
  always_comb begin
    k_nxt     = k_r;
    n_nxt     = n_r;
    cfg_clear = 1'b0;
    if (cfg_valid) begin
      case (cfg_index)
        RegSubsetSize: begin
          k_nxt     = cfg_data[KW-1:0];
          cfg_clear = 1'b1;
        end
        RegPoolSize: begin
          n_nxt     = cfg_data;
          cfg_clear = 1'b1;
        end
        default: begin
          cfg_clear = 1'b0;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      k_r <= ksize_t'(1);
      n_r <= nsize_t'(1);
    end else begin
      k_r <= k_nxt;
      n_r <= n_nxt;
    end
  end

  // Merge the configuration clear into the sequencer's store request.
  always_comb begin
    store_req       = seq_req;
    store_req.clear = seq_req.clear || cfg_clear;
  end

  kce_store u_store (
    .clk     (clk),
    .rst_n   (rst_n),
    .req     (store_req),
    .rd_data (rd_data)
  );

  kce_seq u_seq (
    .clk         (clk),
    .rst_n       (rst_n),
    .k           (k_r),
    .n           (n_r),
    .in_valid    (in_tvalid),
    .in_ready    (in_tready),
    .in_restart  (in_tdata[0]),
    .req         (seq_req),
    .rd_data     (rd_data),
    .out_valid   (out_tvalid),
    .out_ready   (out_tready),
    .out_index   (out_index),
    .out_slot    (out_slot),
    .out_last    (out_tlast),
    .out_wrapped (out_wrapped),
    .out_error   (out_error)
  );

  assign out_tdata = {2'b00, out_slot, out_index};
  assign out_tuser = {out_error, out_wrapped};

endmodule

`default_nettype wire
